/* rtl/peft_pkg.sv */
package peft_pkg;

	localparam int unsigned ENTRIES_DEF = 256;

	localparam logic [2:0] ACT_BEGIN  = 3'd0;
	localparam logic [2:0] ACT_REPORT = 3'd1;
	localparam logic [2:0] ACT_QUERY  = 3'd2;
	localparam logic [2:0] ACT_RESET  = 3'd3;
	localparam logic [2:0] ACT_REMOVE = 3'd4;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic        live;
		logic [31:0] key;
		logic [7:0]  flags;
		logic [31:0] warns;
	} entry_t;

endpackage

/* rtl/per_user_event_flag_table.sv */
// A word is resolved by a linear scan through the entry memory, one slot read per cycle,
// that stops at the first live match; a miss scans every slot below the fill count, and none
// on an empty table. busy drops as done rises. A new word is taken only once the previous
// word has given its result.
// Reset clears the fill count and control state only; the entry memory is not swept,
// and only slots below the fill count are ever checked for a match. Results cannot be stalled.
module per_user_event_flag_table
	import peft_pkg::*;
#(
	parameter int unsigned ENTRIES = ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [2:0]  action,
	input  logic [31:0] user_key,
	input  logic [7:0]  event_type,
	output logic        busy,
	output logic        done,
	output logic [1:0]  status,
	output logic [7:0]  flag_set,
	output logic [31:0] warning_total
);

	localparam int unsigned CW = $clog2(ENTRIES + 1);
	localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef enum logic [1:0] {
		IDLE,
		SCAN,
		DECIDE
	} state_t;

	state_t        state_q;
	logic [CW-1:0] slots_used_q;
	logic [CW-1:0] scan_idx_q;
	logic          chk_vld_s1;
	logic [AW-1:0] chk_idx_s1;
	entry_t        rd_ent_s1;
	logic [2:0]    act_q;
	logic [31:0]   key_q;
	logic [7:0]    ev_q;
	logic          hit_q;
	logic [AW-1:0] slot_q;
	entry_t        ent_q;

	entry_t        mem [ENTRIES];

	logic          issue;
	logic          match;
	logic          full;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_ent;
	entry_t        base_ent;
	logic          bump;
	logic [1:0]    res_status;
	logic [7:0]    res_flags;
	logic [31:0]   res_warns;

	assign issue = (state_q == SCAN) && (scan_idx_q < slots_used_q);
	assign match = chk_vld_s1 && rd_ent_s1.live && (rd_ent_s1.key == key_q);
	assign full  = (slots_used_q == CW'(ENTRIES));
	assign busy  = (state_q != IDLE);

	always_ff @(posedge clk) begin
		// commit only once the decision is taken
		if (wr_en && (state_q == DECIDE)) begin
			mem[wr_addr] <= wr_ent;
		end
		rd_ent_s1  <= mem[scan_idx_q[AW-1:0]];
		chk_idx_s1 <= scan_idx_q[AW-1:0];
	end

	// Resolve the action once the search has settled
	always_comb begin
		wr_en      = 1'b0;
		wr_addr    = slot_q;
		wr_ent     = ent_q;
		bump       = 1'b0;
		res_status = ST_NOT_FOUND;
		res_flags  = '0;
		res_warns  = '0;
		base_ent   = hit_q ? ent_q
		                   : entry_t'{live: 1'b1, key: key_q, flags: 8'd0, warns: 32'd0};
		unique case (act_q) inside
			ACT_BEGIN, ACT_REPORT: begin
				if (hit_q || !full) begin
					wr_en   = 1'b1;
					wr_addr = hit_q ? slot_q : slots_used_q[AW-1:0];
					bump    = !hit_q;
					wr_ent  = base_ent;
					if (act_q == ACT_BEGIN) begin
						wr_ent.flags = '0;
						wr_ent.warns = '0;
					end else begin
						wr_ent.flags = base_ent.flags | ev_q;
						wr_ent.warns = base_ent.warns + 32'd1;
					end
					res_status = ST_OK;
					res_flags  = wr_ent.flags;
					res_warns  = wr_ent.warns;
				end else begin
					res_status = ST_FULL;
				end
			end
			ACT_QUERY: begin
				if (hit_q) begin
					res_status = ST_OK;
					res_flags  = ent_q.flags;
					res_warns  = ent_q.warns;
				end
			end
			ACT_RESET: begin
				if (hit_q) begin
					wr_en        = 1'b1;
					wr_ent.flags = '0;
					wr_ent.warns = '0;
					res_status   = ST_OK;
				end
			end
			ACT_REMOVE: begin
				if (hit_q) begin
					wr_en       = 1'b1;
					wr_ent.live = 1'b0;
					res_status  = ST_OK;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= IDLE;
			slots_used_q  <= '0;
			scan_idx_q    <= '0;
			chk_vld_s1    <= 1'b0;
			done          <= 1'b0;
			status        <= ST_OK;
			flag_set      <= '0;
			warning_total <= '0;
			act_q         <= '0;
			key_q         <= '0;
			ev_q          <= '0;
			hit_q         <= 1'b0;
			slot_q        <= '0;
			ent_q         <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				IDLE: begin
					chk_vld_s1 <= 1'b0;
					if (start) begin
						act_q      <= action;
						key_q      <= user_key;
						ev_q       <= event_type;
						scan_idx_q <= '0;
						state_q    <= SCAN;
					end
				end
				SCAN: begin
					if (match || (!issue && !chk_vld_s1)) begin
						// first live match wins; otherwise the scan ran dry
						hit_q      <= match;
						slot_q     <= chk_idx_s1;
						ent_q      <= rd_ent_s1;
						chk_vld_s1 <= 1'b0;
						state_q    <= DECIDE;
					end else begin
						chk_vld_s1 <= issue;
						if (issue) begin
							scan_idx_q <= CW'(scan_idx_q + 1'b1);
						end
					end
				end
				DECIDE: begin
					if (bump) begin
						slots_used_q <= CW'(slots_used_q + 1'b1);
					end
					done          <= 1'b1;
					status        <= res_status;
					flag_set      <= res_flags;
					warning_total <= res_warns;
					state_q       <= IDLE;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not start a search");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (flag_set == 8'd0 && warning_total == 32'd0))
		else $error("failed action returned entry data");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		slots_used_q <= CW'(ENTRIES))
		else $error("fill count past table depth");

	a_done_after_decide: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == DECIDE))
		else $error("result strobe without a decision");

endmodule

/* verif/tb_per_user_event_flag_table.sv */
`timescale 1ns / 100ps

module tb_per_user_event_flag_table
	import peft_pkg::*;
();

	// first of the unused action codes; the rest follow up to 7
	localparam logic [2:0] ACT_SPARE = ACT_REMOVE + 3'd1;
	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_WORDS = 1830;
	localparam int KEY_POOL_SIZE = 48;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  flags;
		logic [31:0] warns;
	} table_result_t;

	class event_table_tracker;
		logic [31:0]   keys [ENTRIES_DEF];
		logic          live [ENTRIES_DEF];
		logic [7:0]    flags [ENTRIES_DEF];
		logic [31:0]   warns [ENTRIES_DEF];
		int            used;
		table_result_t outstanding [$];
		int            fail_count;

		function new();
			used = 0;
			fail_count = 0;
		endfunction

		task report_mismatch(string msg);
			$display("%0t: mismatch: %s", $time, msg);
			fail_count++;
		endtask

		function int find_live(logic [31:0] key);
			for (int i = 0; i < used; i++)
				if (live[i] && keys[i] == key)
					return i;
			return -1;
		endfunction

		function int pending_count();
			return outstanding.size();
		endfunction

		// Predict the result of one accepted word and update the table copy.
		function void note_word(logic [2:0] act, logic [31:0] key, logic [7:0] ev);
			int slot;
			table_result_t r;
			r = '{ST_NOT_FOUND, 8'd0, 32'd0};
			slot = find_live(key);
			case (act)
				ACT_BEGIN, ACT_REPORT: begin
					if (slot < 0 && used < ENTRIES_DEF) begin
						slot = used;
						keys[slot] = key;
						live[slot] = 1'b1;
						flags[slot] = 8'd0;
						warns[slot] = 32'd0;
						used++;
					end
					if (slot < 0) begin
						r.status = ST_FULL;
					end else begin
						if (act == ACT_BEGIN) begin
							flags[slot] = 8'd0;
							warns[slot] = 32'd0;
						end else begin
							flags[slot] = flags[slot] | ev;
							warns[slot] = warns[slot] + 32'd1;
						end
						r = '{ST_OK, flags[slot], warns[slot]};
					end
				end
				ACT_QUERY: begin
					if (slot >= 0)
						r = '{ST_OK, flags[slot], warns[slot]};
				end
				ACT_RESET: begin
					if (slot >= 0) begin
						flags[slot] = 8'd0;
						warns[slot] = 32'd0;
						r.status = ST_OK;
					end
				end
				ACT_REMOVE: begin
					if (slot >= 0) begin
						live[slot] = 1'b0;
						r.status = ST_OK;
					end
				end
				default: ;
			endcase
			outstanding.push_back(r);
		endfunction

		task check_word(logic [1:0] st, logic [7:0] fl, logic [31:0] wt);
			table_result_t exp_r;
			if (outstanding.size() == 0) begin
				report_mismatch($sformatf("result st=%0d flags=%h warns=%h with none outstanding",
					st, fl, wt));
			end else begin
				exp_r = outstanding.pop_front();
				if (st !== exp_r.status)
					report_mismatch($sformatf("status %0d, want %0d", st, exp_r.status));
				if (fl !== exp_r.flags)
					report_mismatch($sformatf("flag_set %h, want %h", fl, exp_r.flags));
				if (wt !== exp_r.warns)
					report_mismatch($sformatf("warning_total %h, want %h", wt, exp_r.warns));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic [2:0]  action;
	logic [31:0] user_key;
	logic [7:0]  event_type;
	logic        busy;
	logic        done;
	logic [1:0]  status;
	logic [7:0]  flag_set;
	logic [31:0] warning_total;

	event_table_tracker tracker;
	logic [31:0]        key_pool [KEY_POOL_SIZE];
	int                 calm_left;
	int                 idle_cycles;

	per_user_event_flag_table u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.action(action),
		.user_key(user_key),
		.event_type(event_type),
		.busy(busy),
		.done(done),
		.status(status),
		.flag_set(flag_set),
		.warning_total(warning_total)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// results cannot be held off: take every strobe
	always @(posedge clk) begin
		if (arst_n && done)
			tracker.check_word(status, flag_set, warning_total);
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task send_word(logic [2:0] a, logic [31:0] k, logic [7:0] e);
		int gap;
		if (calm_left > 0) begin
			calm_left--;
			gap = 0;
		end else begin
			gap = $urandom_range(0, 10);
			if ($urandom_range(0, 29) == 0)
				calm_left = $urandom_range(15, 50);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		action <= a;
		user_key <= k;
		event_type <= e;
		@(posedge clk);
		while (busy) @(posedge clk);
		tracker.note_word(a, k, e);
	endtask

	// hold off the next word until the table has answered everything
	task drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (tracker.pending_count() != 0) @(posedge clk);
	endtask

	task random_word();
		int          pick;
		logic [2:0]  a;
		logic [31:0] k;
		pick = $urandom_range(0, 99);
		if (pick < 14)
			a = ACT_BEGIN;
		else if (pick < 48)
			a = ACT_REPORT;
		else if (pick < 68)
			a = ACT_QUERY;
		else if (pick < 78)
			a = ACT_RESET;
		else if (pick < 92)
			a = ACT_REMOVE;
		else
			a = ACT_SPARE + 3'($urandom_range(0, 2));
		// fresh keys fill the table; pool keys hit live entries
		if ($urandom_range(0, 99) < 35)
			k = $urandom();
		else
			k = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
		send_word(a, k, 8'($urandom_range(0, 255)));
	endtask

	initial begin
		tracker = new();
		arst_n = 1'b0;
		start = 1'b0;
		action = ACT_BEGIN;
		user_key = 32'd0;
		event_type = 8'd0;
		calm_left = 0;
		key_pool[0] = 32'd0;
		key_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < KEY_POOL_SIZE; i++)
			key_pool[i] = $urandom();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(ACT_QUERY, 32'd0, 8'h00);
		send_word(ACT_BEGIN, 32'd0, 8'hFF);
		send_word(ACT_REPORT, 32'd0, 8'hFF);
		send_word(ACT_REPORT, 32'hFFFF_FFFF, 8'h01);
		send_word(ACT_REPORT, 32'hFFFF_FFFF, 8'h80);
		send_word(ACT_QUERY, 32'd0, 8'h00);
		send_word(ACT_QUERY, 32'hFFFF_FFFF, 8'hFF);
		send_word(ACT_QUERY, 32'h1234_5678, 8'h00);
		send_word(ACT_RESET, 32'd0, 8'h00);
		send_word(ACT_QUERY, 32'd0, 8'h00);
		send_word(ACT_REPORT, 32'd0, 8'h5A);
		send_word(ACT_BEGIN, 32'd0, 8'h00);
		send_word(ACT_REMOVE, 32'hFFFF_FFFF, 8'h00);
		send_word(ACT_QUERY, 32'hFFFF_FFFF, 8'h00);
		send_word(ACT_RESET, 32'hFFFF_FFFF, 8'h00);
		send_word(ACT_REMOVE, 32'hFFFF_FFFF, 8'h00);
		// re-append after remove lands in a fresh slot
		send_word(ACT_REPORT, 32'hFFFF_FFFF, 8'h24);
		send_word(ACT_QUERY, 32'hFFFF_FFFF, 8'h00);
		for (int c = 0; c < 3; c++)
			send_word(ACT_SPARE + 3'(c), 32'd0, 8'hFF);
		drain_results();

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			random_word();
			if ($urandom_range(0, 59) == 0)
				drain_results();
		end

		start <= 1'b0;
		while (tracker.pending_count() != 0) @(posedge clk);
		repeat (ENTRIES_DEF + 8) @(posedge clk);
		if (tracker.fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
